>>> hdl/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types, codes and the B3/S23 cell rule for the toroidal life engine.
// ----------------------------------------------------------------------------
package tlg_pkg;

  // Item field widths
  localparam int FUNC_W     = 2;
  localparam int CELL_IDX_W = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Item operations
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_STEP  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Neighborhood
  localparam int NBR_COUNT = 8;
  localparam int NBR_W     = $clog2(NBR_COUNT + 1);

  localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

  // Generation sequencer: counter values at which the row buffers load and the first step runs
  localparam int GEN_LD_TOP     = 1;
  localparam int GEN_LD_MID     = 2;
  localparam int GEN_FIRST_STEP = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;          // capture item fields
    logic rd_en;        // memory read
    logic rd_gen;       // read address from the generation sequencer
    logic ld_top;       // load row-above buffer
    logic ld_mid;       // load center buffer and saved first row
    logic step;         // compute and write one new row, shift buffers
    logic use_first;    // row below is the saved first row
    logic set_wr;       // write back the modified row of a set
    logic clr;          // clear the whole grid
    logic ld_out_zero;  // result register takes 0
    logic ld_out_read;  // result register takes the cell read
  } tlg_cmd_t;

  function automatic logic life_next(input logic alive, input logic [NBR_W-1:0] cnt);
    return (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

>>> hdl/tlg_datapath.sv
// ----------------------------------------------------------------------------
// tlg_datapath
// Grid row memory, row valid bits, line buffers, new-row lanes and the
// configuration and result registers.
// ----------------------------------------------------------------------------
module tlg_datapath import tlg_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata,
  input  logic [CELL_IDX_W-1:0]              in_cell_row,
  input  logic [CELL_IDX_W-1:0]              in_cell_col,
  input  logic                               in_cell_in,
  input  tlg_cmd_t                           cmd,
  input  logic [$clog2(MAX_ROWS)-1:0]        gen_rd_row,
  input  logic [$clog2(MAX_ROWS)-1:0]        gen_wr_row,
  output logic [$clog2(MAX_ROWS+1)-1:0]      nr,
  output logic                               out_cell_out
);

  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int RIW  = $clog2(MAX_ROWS + 1);
  localparam int CIW  = $clog2(MAX_COLS + 1);
  localparam int RCW  = (RIW > CELL_IDX_W) ? RIW : CELL_IDX_W;
  localparam int CCW  = (CIW > CELL_IDX_W) ? CIW : CELL_IDX_W;
  localparam int RVW  = (RIW > CFG_DATA_W) ? RIW : CFG_DATA_W;
  localparam int CVW  = (CIW > CFG_DATA_W) ? CIW : CFG_DATA_W;

  // Size registers hold the effective (clamped) sizes
  logic [RIW-1:0] nr_r;
  logic [CIW-1:0] nc_r;
  logic [RIW-1:0] nr_clamp;
  logic [CIW-1:0] nc_clamp;
  logic           cfg_clr;

  always_comb begin
    if (cfg_wdata == '0) begin
      nr_clamp = RIW'(1);
    end else if (RVW'(cfg_wdata) > RVW'(MAX_ROWS)) begin
      nr_clamp = RIW'(MAX_ROWS);
    end else begin
      nr_clamp = RIW'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      nc_clamp = CIW'(1);
    end else if (CVW'(cfg_wdata) > CVW'(MAX_COLS)) begin
      nc_clamp = CIW'(MAX_COLS);
    end else begin
      nc_clamp = CIW'(cfg_wdata);
    end
  end

  assign cfg_clr = cfg_wr_en && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r <= RIW'(MAX_ROWS);
      nc_r <= CIW'(MAX_COLS);
    end else if (cfg_wr_en && (cfg_index == REG_ROWS)) begin
      nr_r <= nr_clamp;
    end else if (cfg_wr_en && (cfg_index == REG_COLS)) begin
      nc_r <= nc_clamp;
    end
  end

  assign nr = nr_r;

  // Item capture
  logic [RAW-1:0] item_row_r;
  logic [CAW-1:0] item_col_r;
  logic           item_val_r;
  logic           item_in_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_row_r <= RAW'(in_cell_row);
      item_col_r <= CAW'(in_cell_col);
      item_val_r <= in_cell_in;
      item_in_r  <= (RCW'(in_cell_row) < RCW'(nr_r)) && (CCW'(in_cell_col) < CCW'(nc_r));
    end
  end

  // Row memory, registered read
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [RAW-1:0]      rd_addr;
  logic                wr_en;
  logic [RAW-1:0]      wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [MAX_COLS-1:0] row_q;
  logic [MAX_COLS-1:0] set_row;
  logic [MAX_COLS-1:0] next_row;

  assign rd_addr = cmd.rd_gen ? gen_rd_row : RAW'(in_cell_row);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // A row never written since the last clear reads as all dead
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr || cfg_clr) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign row_q = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    set_row             = row_q;
    set_row[item_col_r] = item_val_r;
  end

  assign wr_en   = cmd.step || (cmd.set_wr && item_in_r);
  assign wr_addr = cmd.step ? gen_wr_row : item_row_r;
  assign wr_data = cmd.step ? next_row : set_row;

  // Line buffers
  logic [MAX_COLS-1:0] top_r;
  logic [MAX_COLS-1:0] mid_r;
  logic [MAX_COLS-1:0] first_r;
  logic [MAX_COLS-1:0] below;
  logic [CAW-1:0]      nc_m1;

  assign below = cmd.use_first ? first_r : row_q;
  assign nc_m1 = CAW'(nc_r - CIW'(1));

  always_ff @(posedge clk) begin
    if (cmd.ld_top) begin
      top_r <= row_q;
    end
    if (cmd.ld_mid) begin
      mid_r   <= row_q;
      first_r <= row_q;
    end
    if (cmd.step) begin
      top_r <= mid_r;
      mid_r <= below;
    end
  end

  // One lane per column; wrap at the column in use
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic             t_l, t_r, m_l, m_r, b_l, b_r;
    logic             right_wrap;
    logic [NBR_W-1:0] cnt;

    assign right_wrap = CIW'(c + 1) >= nc_r;

    if (c == 0) begin : g_left_wrap
      assign t_l = top_r[nc_m1];
      assign m_l = mid_r[nc_m1];
      assign b_l = below[nc_m1];
    end else begin : g_left
      assign t_l = top_r[c-1];
      assign m_l = mid_r[c-1];
      assign b_l = below[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_edge
      assign t_r = top_r[0];
      assign m_r = mid_r[0];
      assign b_r = below[0];
    end else begin : g_right
      assign t_r = right_wrap ? top_r[0] : top_r[c+1];
      assign m_r = right_wrap ? mid_r[0] : mid_r[c+1];
      assign b_r = right_wrap ? below[0] : below[c+1];
    end

    assign cnt = NBR_W'(t_l) + NBR_W'(top_r[c]) + NBR_W'(t_r)
               + NBR_W'(m_l) + NBR_W'(m_r)
               + NBR_W'(b_l) + NBR_W'(below[c]) + NBR_W'(b_r);

    assign next_row[c] = (CIW'(c) < nc_r) && life_next(mid_r[c], cnt);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out_zero) begin
      out_cell_out <= 1'b0;
    end else if (cmd.ld_out_read) begin
      out_cell_out <= item_in_r && row_q[item_col_r];
    end
  end

endmodule

>>> hdl/tlg_ctrl.sv
// ----------------------------------------------------------------------------
// tlg_ctrl
// Item sequencer: handshakes, result valid and the row schedule of a
// generation step.
// ----------------------------------------------------------------------------
module tlg_ctrl import tlg_pkg::*; #(
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [FUNC_W-1:0]              in_func,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  nr,
  output tlg_cmd_t                       cmd,
  output logic [$clog2(MAX_ROWS)-1:0]    gen_rd_row,
  output logic [$clog2(MAX_ROWS)-1:0]    gen_wr_row
);

  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int RIW  = $clog2(MAX_ROWS + 1);
  localparam int CNTW = $clog2(MAX_ROWS + 3);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SET  = 4'b0100,
    ST_GEN  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_taken;
  logic [CNTW-1:0] nr_ext;
  logic            gen_last;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_taken = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  assign nr_ext   = CNTW'(nr);
  assign gen_last = cnt_r == (nr_ext + CNTW'(2));

  assign gen_rd_row = (cnt_r == '0) ? RAW'(nr - RIW'(1)) : RAW'(cnt_r - CNTW'(1));
  assign gen_wr_row = gen_last ? RAW'(nr - RIW'(1)) : RAW'(cnt_r - CNTW'(GEN_FIRST_STEP));

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          cmd.cap = 1'b1;
          case (func_t'(in_func))
            FUNC_SET: begin
              cmd.rd_en       = 1'b1;
              cmd.ld_out_zero = 1'b1;
              state_nxt       = ST_SET;
            end
            FUNC_CLEAR: begin
              cmd.clr         = 1'b1;
              cmd.ld_out_zero = 1'b1;
            end
            FUNC_STEP: begin
              cmd.ld_out_zero = 1'b1;
              state_nxt       = ST_GEN;
            end
            FUNC_READ: begin
              cmd.rd_en = 1'b1;
              state_nxt = ST_READ;
            end
            default: begin
              cmd.ld_out_zero = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.ld_out_read = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_SET: begin
        cmd.set_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_GEN: begin
        cmd.rd_gen    = 1'b1;
        cmd.rd_en     = cnt_r <= nr_ext;
        cmd.ld_top    = cnt_r == CNTW'(GEN_LD_TOP);
        cmd.ld_mid    = cnt_r == CNTW'(GEN_LD_MID);
        cmd.step      = cnt_r >= CNTW'(GEN_FIRST_STEP);
        cmd.use_first = gen_last;
        cnt_nxt       = cnt_r + CNTW'(1);
        if (gen_last) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.ld_out_zero || cmd.ld_out_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_taken) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The read and set follow-up states always return to idle on the next cycle
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) || (state_r == ST_SET) |=> (state_r == ST_IDLE))
    else $error("read/set follow-up did not return to idle");

  // Generation counter stays within rows + 2
  a_gen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (cnt_r <= (nr_ext + CNTW'(2))))
    else $error("generation counter overran");

  // Generation reads and writes stay inside the rows in use
  a_gen_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) && cmd.step |-> (RIW'(gen_wr_row) < nr))
    else $error("generation write outside rows in use");

  a_gen_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) && cmd.rd_en |-> (RIW'(gen_rd_row) < nr))
    else $error("generation read outside rows in use");

  // A result only appears after an accept or a cell read
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_IDLE) || ($past(state_r) == ST_READ))
    else $error("result valid raised from an unexpected state");

endmodule

>>> hdl/toroidal_life_generation_engine_unit.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine_unit
// Toroidal B3/S23 life grid with cell set, clear, read and generation step.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, one result transfer per item. A clear
// completes in its accept cycle; a set or read does a registered read of the
// row memory, then loads the result or writes the row back. A generation step
// follows its accept with a pass in which the row memory's read port reads
// each row once plus one extra read of the last row, while three line buffers
// (row above, center row, saved original first row) feed MAX_COLS
// neighbor-count lanes that write one new row per cycle back into the memory.
// The result of a non-read item is loaded at accept, so a waiting result
// never blocks the next accept unless the output register is full and
// stalled. Clear and any write to either size register reset all per-row
// valid bits together; there is no clearing pass. Sizes of 0 act as 1, sizes
// above MAX_ROWS or MAX_COLS act as the maximum; sets outside the area in use
// are dropped and reads there return 0. Configuration is to be written only
// while no item is open; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine_unit import tlg_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [CELL_IDX_W-1:0] in_cell_row,
  input  logic [CELL_IDX_W-1:0] in_cell_col,
  input  logic                  in_cell_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_cell_out,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int RIW = $clog2(MAX_ROWS + 1);

  tlg_cmd_t       cmd;
  logic [RAW-1:0] gen_rd_row;
  logic [RAW-1:0] gen_wr_row;
  logic [RIW-1:0] nr;

  // Sequencer: handshakes and the per-row schedule of a generation
  tlg_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .nr         (nr),
    .cmd        (cmd),
    .gen_rd_row (gen_rd_row),
    .gen_wr_row (gen_wr_row)
  );

  // Grid memory, line buffers, cell lanes, size and result registers
  tlg_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_in   (in_cell_in),
    .cmd          (cmd),
    .gen_rd_row   (gen_rd_row),
    .gen_wr_row   (gen_wr_row),
    .nr           (nr),
    .out_cell_out (out_cell_out)
  );

endmodule

>>> dv/toroidal_life_generation_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine_unit_tb
// Self-checking bench for the toroidal B3/S23 life grid engine.
// Every item transfer is predicted by a behavioral copy of the grid. Each
// result transfer is checked against the oldest predicted cell value. The
// run covers directed edge and wrap cases, then random item streams over
// many grid sizes, with random idling on both channels and one long output
// hold.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine_unit_tb;
  import tlg_pkg::*;

  localparam int GRID_ROWS     = 64;
  localparam int GRID_COLS     = 64;
  // A generation step keeps running after its result is already out,
  // so let a full step finish before touching the size registers.
  localparam int SETTLE_CYCLES = GRID_ROWS + 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 34;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func;
  logic [CELL_IDX_W-1:0] in_cell_row;
  logic [CELL_IDX_W-1:0] in_cell_col;
  logic                  in_cell_in;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_cell_out;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  toroidal_life_generation_engine_unit #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_cell_row (in_cell_row),
    .in_cell_col (in_cell_col),
    .in_cell_in  (in_cell_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_cell_out(out_cell_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predicted grid state: raw register values plus the cell array.
  // --------------------------------------------------------------------------
  logic [GRID_COLS-1:0]  cell_grid [GRID_ROWS];
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  logic                  expected_cells [$];
  logic                  exp_cell;

  int errors       = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int reads_sent   = 0;
  int steps_sent   = 0;
  int sizes_run    = 0;

  // Idling control. quiet turns off random gaps on both sides; a new hold
  // request (hold_asks ahead of hold_done) makes the receiver hold out_stall
  // high until its hold counter, loaded from HOLD_CYCLES, runs out.
  logic quiet     = 1'b0;
  int   hold_asks = 0;
  int   hold_done = 0;
  int   hold_left = 0;

  // Size register value to the size actually used: 0 acts as 1, big clamps.
  function automatic int used_size(input logic [CFG_DATA_W-1:0] v, input int max_n);
    if (v == '0) return 1;
    if (int'(v) > max_n) return max_n;
    return int'(v);
  endfunction

  function automatic int wrap_pos(input int pos, input int d, input int n);
    if (d > 0) return (pos + 1 >= n) ? 0 : pos + 1;
    if (d < 0) return (pos == 0) ? n - 1 : pos - 1;
    return pos;
  endfunction

  function automatic void clear_grid();
    foreach (cell_grid[r]) cell_grid[r] = '0;
  endfunction

  // One B3/S23 generation over the area in use, all cells at once. On tiny
  // grids a wrapped neighbor can be the same cell (or the cell itself) more
  // than once; each position counts.
  function automatic void next_generation();
    logic [GRID_COLS-1:0] fresh [GRID_ROWS];
    int nr, nc, cnt, r, c, dr, dc;
    nr = used_size(rows_reg, GRID_ROWS);
    nc = used_size(cols_reg, GRID_COLS);
    fresh = cell_grid;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        cnt = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0)
              cnt += int'(cell_grid[wrap_pos(r, dr, nr)][wrap_pos(c, dc, nc)]);
          end
        end
        fresh[r][c] = (cnt == int'(BIRTH_CNT)) ||
                      (cell_grid[r][c] && cnt == int'(SURVIVE_CNT));
      end
    end
    cell_grid = fresh;
  endfunction

  // Apply one accepted item to the grid and queue the cell value it returns.
  function automatic void predict_cell(input func_t f, input int row, input int col,
                                       input logic val);
    logic in_area;
    logic res;
    in_area = (row < used_size(rows_reg, GRID_ROWS)) && (col < used_size(cols_reg, GRID_COLS));
    res     = 1'b0;
    case (f)
      FUNC_SET:   if (in_area) cell_grid[row][col] = val;
      FUNC_CLEAR: clear_grid();
      FUNC_STEP:  next_generation();
      default:    if (in_area) res = cell_grid[row][col];
    endcase
    expected_cells.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, long hold on request, and the checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("result transfer with nothing expected: cell_out %0b", out_cell_out);
        errors++;
      end else begin
        exp_cell = expected_cells.pop_front();
        results_seen++;
        if (out_cell_out !== exp_cell) begin
          $error("cell_out mismatch: expected %0b, actual %0b", exp_cell, out_cell_out);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item side. Tasks start and end right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input func_t f, input int row, input int col, input logic val);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_cell_row <= CELL_IDX_W'(row);
    in_cell_col <= CELL_IDX_W'(col);
    in_cell_in  <= val;
    // hold the payload until the transfer happens
    do @(posedge clk); while (in_stall);
    predict_cell(f, row, col, val);
    items_sent++;
    if (f == FUNC_READ) reads_sent++;
    if (f == FUNC_STEP) steps_sent++;
  endtask

  // Stop offering items, wait for every result, then let a step in flight end.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle. Known indexes resize and clear the grid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROWS) begin
      rows_reg = CFG_DATA_W'(val);
      clear_grid();
    end else if (idx == REG_COLS) begin
      cols_reg = CFG_DATA_W'(val);
      clear_grid();
    end
  endtask

  task automatic set_size(input int rows, input int cols);
    wait_idle();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    sizes_run++;
  endtask

  // Mostly sets and reads inside the area in use, with generation steps
  // mixed in so patterns evolve; some coordinates land anywhere in 0..63.
  task automatic random_item();
    int    nr, nc, pick, row, col;
    func_t f;
    nr   = used_size(rows_reg, GRID_ROWS);
    nc   = used_size(cols_reg, GRID_COLS);
    pick = $urandom_range(0, 99);
    if (pick < 45)      f = FUNC_SET;
    else if (pick < 80) f = FUNC_READ;
    else if (pick < 96) f = FUNC_STEP;
    else                f = FUNC_CLEAR;
    row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nr - 1) : $urandom_range(0, 63);
    col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nc - 1) : $urandom_range(0, 63);
    send_item(f, row, col, $urandom_range(0, 99) < 70);
  endtask

  task automatic run_phase(input int rows, input int cols, input int n);
    set_size(rows, cols);
    repeat (n) random_item();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Full 64x64 grid from reset: corners, a blinker that wraps both edges,
  // killing a cell with a set of 0, and clear.
  task automatic test_wrap_blinker();
    send_item(FUNC_SET, 0, 63, 1'b1);
    send_item(FUNC_SET, 0, 0, 1'b1);
    send_item(FUNC_SET, 0, 1, 1'b1);
    send_item(FUNC_READ, 0, 0, 1'b0);
    send_item(FUNC_READ, 63, 0, 1'b1);
    send_item(FUNC_STEP, 63, 63, 1'b1);
    send_item(FUNC_READ, 63, 0, 1'b0);
    send_item(FUNC_READ, 1, 0, 1'b0);
    send_item(FUNC_READ, 0, 63, 1'b0);
    send_item(FUNC_SET, 1, 0, 1'b0);
    send_item(FUNC_READ, 1, 0, 1'b0);
    send_item(FUNC_CLEAR, 0, 0, 1'b0);
    send_item(FUNC_READ, 0, 0, 1'b0);
  endtask

  // Cells outside the area in use, a 1x1 grid where all eight neighbors are
  // the cell itself, zero and oversized register values, unknown indexes.
  task automatic test_sizes_and_bounds();
    set_size(5, 6);
    send_item(FUNC_SET, 5, 0, 1'b1);
    send_item(FUNC_READ, 5, 0, 1'b1);
    send_item(FUNC_SET, 4, 5, 1'b1);
    send_item(FUNC_READ, 4, 5, 1'b0);
    set_size(1, 1);
    send_item(FUNC_SET, 0, 0, 1'b1);
    send_item(FUNC_STEP, 0, 0, 1'b0);
    send_item(FUNC_READ, 0, 0, 1'b0);
    set_size(0, 0);
    send_item(FUNC_SET, 0, 0, 1'b1);
    send_item(FUNC_READ, 0, 1, 1'b0);
    set_size(127, 127);
    send_item(FUNC_SET, 63, 63, 1'b1);
    // unknown indexes must leave the grid alone
    wait_idle();
    write_reg(REG_SPARE_A, 7'h55);
    write_reg(REG_SPARE_B, 7'h2a);
    send_item(FUNC_READ, 63, 63, 1'b0);
  endtask

  // Receiver holds off long enough to back the block up while items keep
  // coming, then the sender waits for every result before going on.
  task automatic test_backpressure();
    set_size(16, 13);
    repeat (40) random_item();
    hold_asks <= hold_asks + 1;
    repeat (40) random_item();
    wait_idle();
    repeat (40) random_item();
  endtask

  // A long stretch with no gaps on either side.
  task automatic test_no_idle();
    quiet <= 1'b1;
    run_phase(8, 8, 120);
    quiet <= 1'b0;
  endtask

  task automatic test_random_sizes();
    run_phase(4, 4, 80);
    run_phase(1, 1, 30);
    run_phase(2, 3, 40);
    run_phase(0, 2, 30);
    run_phase(127, 127, 60);
    run_phase(64, 5, 40);
    run_phase(5, 64, 40);
    repeat (3) run_phase($urandom_range(1, 12), $urandom_range(1, 12), 50);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FUNC_SET;
    in_cell_row = '0;
    in_cell_col = '0;
    in_cell_in  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_ROWS;
    cfg_wdata   = '0;
    rows_reg    = CFG_DATA_W'(GRID_ROWS);
    cols_reg    = CFG_DATA_W'(GRID_COLS);
    clear_grid();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wrap_blinker();
    test_sizes_and_bounds();
    test_no_idle();
    test_backpressure();
    test_random_sizes();
    wait_idle();

    $display("Ran %0d items (%0d reads, %0d generation steps) over %0d grid sizes;",
             items_sent, reads_sent, steps_sent, sizes_run);
    $display("checked %0d result transfers, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
